@@ sv/skt_pkg.sv @@
// Shared types and constants of the sorted keyed table.
package skt_pkg;

   localparam int CMD_BITS     = 2;
   localparam int REQ_KEY_BITS = 32;
   localparam int WEIGHT_BITS  = 16;
   localparam int COLOR_BITS   = 8;
   localparam int STATUS_BITS  = 2;
   localparam int POS_BITS     = 5;

   // command codes
   localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_FLAG   = 2'd2;

   // status codes
   localparam logic [STATUS_BITS-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd2;

   // read address relative to the current index
   typedef enum logic [2:0] {
      RD_DOWN2,
      RD_DOWN1,
      RD_SAME,
      RD_UP1,
      RD_UP2
   } rd_off_type;

   typedef enum logic [1:0] {
      IDX_HOLD,
      IDX_INC,
      IDX_DEC
   } idx_op_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_NEW,
      WR_COPY,
      WR_FLAG
   } wr_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef enum logic [1:0] {
      POS_ZERO,
      POS_IDX,
      POS_HELD
   } pos_sel_type;

   typedef struct packed {
      logic                   load;
      rd_off_type             rd_off;
      idx_op_type             idx_op;
      wr_op_type              wr_op;
      cnt_op_type             cnt_op;
      logic                   mark_pos;
      logic                   finish;
      logic [STATUS_BITS-1:0] status;
      pos_sel_type            pos_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_BITS-1:0] cmd;
      logic                full;
      logic                ins_stop;
      logic                scan_end;
      logic                key_hit;
      logic                shift_end;
   } dp_stat_type;

endpackage

@@ sv/skt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module skt_ram #(
   parameter int WIDTH = 58,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/skt_ctrl.sv @@
// Controller state machine of the sorted keyed table.
module skt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  skt_pkg::dp_stat_type stat,
   output skt_pkg::ctrl_cmd_type cmd,
   output logic                 busy
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PREP = 5'b00010,
      ST_INS  = 5'b00100,
      ST_SCAN = 5'b01000,
      ST_DEL  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            case (stat.cmd)
               skt_pkg::CMD_INSERT: begin
                  if (stat.full) begin
                     cmd.finish  = 1'b1;
                     cmd.status  = skt_pkg::STATUS_FULL;
                     cmd.pos_sel = skt_pkg::POS_ZERO;
                     state_in    = ST_IDLE;
                  end else begin
                     cmd.rd_off = skt_pkg::RD_DOWN1;
                     state_in   = ST_INS;
                  end
               end
               skt_pkg::CMD_DELETE, skt_pkg::CMD_FLAG: begin
                  cmd.rd_off = skt_pkg::RD_SAME;
                  state_in   = ST_SCAN;
               end
               default: begin
                  cmd.finish  = 1'b1;
                  cmd.status  = skt_pkg::STATUS_DONE;
                  cmd.pos_sel = skt_pkg::POS_ZERO;
                  state_in    = ST_IDLE;
               end
            endcase
         end
         ST_INS: begin
            if (stat.ins_stop) begin
               cmd.wr_op   = skt_pkg::WR_NEW;
               cmd.cnt_op  = skt_pkg::CNT_INC;
               cmd.finish  = 1'b1;
               cmd.status  = skt_pkg::STATUS_DONE;
               cmd.pos_sel = skt_pkg::POS_IDX;
               state_in    = ST_IDLE;
            end else begin
               cmd.wr_op  = skt_pkg::WR_COPY;
               cmd.idx_op = skt_pkg::IDX_DEC;
               cmd.rd_off = skt_pkg::RD_DOWN2;
            end
         end
         ST_SCAN: begin
            cmd.rd_off = skt_pkg::RD_UP1;
            if (stat.scan_end) begin
               cmd.finish  = 1'b1;
               cmd.status  = skt_pkg::STATUS_NOT_FOUND;
               cmd.pos_sel = skt_pkg::POS_ZERO;
               state_in    = ST_IDLE;
            end else if (stat.key_hit) begin
               if (stat.cmd == skt_pkg::CMD_FLAG) begin
                  cmd.wr_op   = skt_pkg::WR_FLAG;
                  cmd.finish  = 1'b1;
                  cmd.status  = skt_pkg::STATUS_DONE;
                  cmd.pos_sel = skt_pkg::POS_IDX;
                  state_in    = ST_IDLE;
               end else begin
                  cmd.mark_pos = 1'b1;
                  state_in     = ST_DEL;
               end
            end else begin
               cmd.idx_op = skt_pkg::IDX_INC;
            end
         end
         ST_DEL: begin
            if (stat.shift_end) begin
               cmd.cnt_op  = skt_pkg::CNT_DEC;
               cmd.finish  = 1'b1;
               cmd.status  = skt_pkg::STATUS_DONE;
               cmd.pos_sel = skt_pkg::POS_HELD;
               state_in    = ST_IDLE;
            end else begin
               cmd.wr_op  = skt_pkg::WR_COPY;
               cmd.idx_op = skt_pkg::IDX_INC;
               cmd.rd_off = skt_pkg::RD_UP2;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

@@ sv/skt_datapath.sv @@
// Datapath of the sorted keyed table: held request, index, count, table RAM, result.
module skt_datapath #(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [skt_pkg::CMD_BITS-1:0]        req_command,
   input  logic [skt_pkg::REQ_KEY_BITS-1:0]    req_key,
   input  logic [skt_pkg::WEIGHT_BITS-1:0]     req_weight,
   input  logic [skt_pkg::COLOR_BITS-1:0]      req_color_code,
   input  logic                                req_peel_edible,
   input  logic                                req_spiky,
   input  skt_pkg::ctrl_cmd_type               cmd,
   output skt_pkg::dp_stat_type                stat,
   output logic                                rsp_strobe,
   output logic [skt_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [skt_pkg::POS_BITS-1:0]        rsp_position,
   output logic [skt_pkg::POS_BITS-1:0]        rsp_entry_total
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int ENTRY_BITS = KEY_BITS + skt_pkg::WEIGHT_BITS + skt_pkg::COLOR_BITS + 2;

   // held request
   logic [skt_pkg::CMD_BITS-1:0]    cmd_ff;
   logic [KEY_BITS-1:0]             key_ff;
   logic [skt_pkg::WEIGHT_BITS-1:0] weight_ff;
   logic [skt_pkg::COLOR_BITS-1:0]  color_ff;
   logic                            peel_ff;
   logic                            spiky_ff;

   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] held_pos_ff;

   logic                            rsp_strobe_ff;
   logic [skt_pkg::STATUS_BITS-1:0] rsp_status_ff;
   logic [skt_pkg::POS_BITS-1:0]    rsp_position_ff;
   logic [skt_pkg::POS_BITS-1:0]    rsp_total_ff;

   logic [KEY_BITS+skt_pkg::REQ_KEY_BITS-1:0] key_wide;
   logic [CW-1:0]                   rd_wide;
   logic [AW-1:0]                   rd_addr;
   logic [ENTRY_BITS-1:0]           rd_data;
   logic [KEY_BITS-1:0]             rd_key;
   logic [skt_pkg::WEIGHT_BITS-1:0] rd_weight;
   logic                            wr_en;
   logic [ENTRY_BITS-1:0]           wr_data;
   logic [ENTRY_BITS-1:0]           new_entry;
   logic [CW-1:0]                   pos_pick;
   logic [skt_pkg::POS_BITS+CW-1:0] pos_wide;
   logic [skt_pkg::POS_BITS+CW-1:0] total_wide;

   // keep only the low KEY_BITS of the request key, zero-extend if wider
   assign key_wide = {{KEY_BITS{1'b0}}, req_key};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff    <= req_command;
         key_ff    <= key_wide[KEY_BITS-1:0];
         weight_ff <= req_weight;
         color_ff  <= req_color_code;
         peel_ff   <= req_peel_edible;
         spiky_ff  <= req_spiky;
      end
      if (cmd.mark_pos) begin
         held_pos_ff <= idx_ff;
      end
      idx_ff <= idx_in;
      if (cmd.finish) begin
         rsp_status_ff   <= cmd.status;
         rsp_position_ff <= pos_wide[skt_pkg::POS_BITS-1:0];
         rsp_total_ff    <= total_wide[skt_pkg::POS_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= cmd.finish;
      end
   end

   // index: insert walks down from the count, scans walk up from zero
   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = (req_command == skt_pkg::CMD_INSERT) ? count_ff : '0;
      end else begin
         case (cmd.idx_op)
            skt_pkg::IDX_INC: idx_in = idx_ff + CW'(1);
            skt_pkg::IDX_DEC: idx_in = idx_ff - CW'(1);
            default:          idx_in = idx_ff;
         endcase
      end
   end

   always_comb begin
      case (cmd.cnt_op)
         skt_pkg::CNT_INC: count_in = count_ff + CW'(1);
         skt_pkg::CNT_DEC: count_in = count_ff - CW'(1);
         default:          count_in = count_ff;
      endcase
   end

   always_comb begin
      case (cmd.rd_off)
         skt_pkg::RD_DOWN2: rd_wide = idx_ff - CW'(2);
         skt_pkg::RD_DOWN1: rd_wide = idx_ff - CW'(1);
         skt_pkg::RD_UP1:   rd_wide = idx_ff + CW'(1);
         skt_pkg::RD_UP2:   rd_wide = idx_ff + CW'(2);
         default:           rd_wide = idx_ff;
      endcase
   end

   assign rd_addr = rd_wide[AW-1:0];

   assign new_entry = {key_ff, weight_ff, color_ff, peel_ff, spiky_ff};

   always_comb begin
      case (cmd.wr_op)
         skt_pkg::WR_NEW:  wr_data = new_entry;
         skt_pkg::WR_FLAG: wr_data = {rd_data[ENTRY_BITS-1:1], 1'b1};
         default:          wr_data = rd_data;
      endcase
   end

   assign wr_en = (cmd.wr_op != skt_pkg::WR_NONE);

   skt_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_key    = rd_data[ENTRY_BITS-1 -: KEY_BITS];
   assign rd_weight = rd_data[ENTRY_BITS-KEY_BITS-1 -: skt_pkg::WEIGHT_BITS];

   always_comb begin
      stat.cmd       = cmd_ff;
      stat.full      = (count_ff == CW'(DEPTH));
      stat.ins_stop  = (idx_ff == '0) || (weight_ff > rd_weight);
      stat.scan_end  = (idx_ff == count_ff);
      stat.key_hit   = (rd_key == key_ff);
      stat.shift_end = ({1'b0, idx_ff} + (CW+1)'(1)) >= {1'b0, count_ff};
   end

   always_comb begin
      case (cmd.pos_sel)
         skt_pkg::POS_IDX:  pos_pick = idx_ff;
         skt_pkg::POS_HELD: pos_pick = held_pos_ff;
         default:           pos_pick = '0;
      endcase
   end

   assign pos_wide   = {{skt_pkg::POS_BITS{1'b0}}, pos_pick};
   assign total_wide = {{skt_pkg::POS_BITS{1'b0}}, count_in};

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_entry_total = rsp_total_ff;

endmodule

@@ sv/sorted_keyed_table.sv @@
// Top level of the sorted keyed table: controller plus datapath.
//
//   channel   ports                                    handshake
//   --------  ---------------------------------------  ---------------------------
//   request   req_command req_key req_weight           start high while busy low
//             req_color_code req_peel_edible req_spiky
//   response  rsp_status rsp_position rsp_entry_total  rsp_strobe, one cycle each
//
// One command is handled at a time. A beat is taken while idle, the next
// cycle issues the first table read, then the table RAM is walked one entry a
// cycle (one read and one write port): insert takes up to count + 1 steps,
// delete and set-flag up to count + 1 steps. Busy stays high from the accepting
// edge until the walk ends; the response beat shows in the cycle busy drops, so
// the next beat can be taken at the end of that cycle. Reset clears the count
// and the controller; table entries at or above the count are never used, so
// the RAM needs no clearing. The receiver cannot stall.
module sorted_keyed_table #(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [skt_pkg::CMD_BITS-1:0]        req_command,
   input  logic [skt_pkg::REQ_KEY_BITS-1:0]    req_key,
   input  logic [skt_pkg::WEIGHT_BITS-1:0]     req_weight,
   input  logic [skt_pkg::COLOR_BITS-1:0]      req_color_code,
   input  logic                                req_peel_edible,
   input  logic                                req_spiky,
   output logic                                rsp_strobe,
   output logic [skt_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [skt_pkg::POS_BITS-1:0]        rsp_position,
   output logic [skt_pkg::POS_BITS-1:0]        rsp_entry_total
);

   skt_pkg::ctrl_cmd_type ctrl_cmd;
   skt_pkg::dp_stat_type  dp_stat;

   // sequence the walk over the table
   skt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (dp_stat),
      .cmd   (ctrl_cmd),
      .busy  (busy)
   );

   // hold the beat, shift entries, register the response
   skt_datapath #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_command),
      .req_key         (req_key),
      .req_weight      (req_weight),
      .req_color_code  (req_color_code),
      .req_peel_edible (req_peel_edible),
      .req_spiky       (req_spiky),
      .cmd             (ctrl_cmd),
      .stat            (dp_stat),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_entry_total (rsp_entry_total)
   );

endmodule

@@ sv/skt_checker.sv @@
// Port-level checks of the sorted keyed table and their bind.
module skt_checker #(
   parameter int DEPTH = 16
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_strobe,
   input logic [skt_pkg::STATUS_BITS-1:0] rsp_status,
   input logic [skt_pkg::POS_BITS-1:0]    rsp_position,
   input logic [skt_pkg::POS_BITS-1:0]    rsp_entry_total
);

   localparam logic [skt_pkg::POS_BITS-1:0] DEPTH_LOW = skt_pkg::POS_BITS'(DEPTH);

   // an accepted beat makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   // a response beat lasts one cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held longer than one cycle");

   // the end of every command delivers its response
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a response");

   // a refused or missed command reports no position
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != skt_pkg::STATUS_DONE)) |-> (rsp_position == '0))
      else $error("nonzero position on a failed command");

   // a full refusal reports a full table
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == skt_pkg::STATUS_FULL)) |-> (rsp_entry_total == DEPTH_LOW))
      else $error("full status with a table that is not full");

endmodule

bind sorted_keyed_table skt_checker #(
   .DEPTH (DEPTH)
) u_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_status      (rsp_status),
   .rsp_position    (rsp_position),
   .rsp_entry_total (rsp_entry_total)
);

@@ tb/tb.sv @@
// Self-checking testbench for the sorted keyed table: directed and random command beats.
`timescale 1ns / 100ps

module tb;

   localparam int TABLE_DEPTH   = 16;
   localparam int KEY_POOL_SIZE = 12;
   localparam int RANDOM_CMDS   = 1250;
   localparam int IDLE_PCT      = 26;
   // issue window (by beat number) where the sender never idles
   localparam int CALM_FIRST    = 500;
   localparam int CALM_LAST     = 750;
   localparam int DRAIN_CYCLES  = TABLE_DEPTH + 8;
   localparam int TIMEOUT_NS    = 5_000_000;

   // command code the block must ignore
   localparam logic [skt_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [skt_pkg::REQ_KEY_BITS-1:0] key;
      logic [skt_pkg::WEIGHT_BITS-1:0]  weight;
      logic [skt_pkg::COLOR_BITS-1:0]   color;
      logic                             peel;
      logic                             spiky;
   } table_entry_type;

   typedef struct {
      logic [skt_pkg::CMD_BITS-1:0]     command;
      logic [skt_pkg::REQ_KEY_BITS-1:0] key;
      logic [skt_pkg::WEIGHT_BITS-1:0]  weight;
      logic [skt_pkg::COLOR_BITS-1:0]   color;
      logic                             peel;
      logic                             spiky;
   } table_cmd_type;

   typedef struct {
      logic [skt_pkg::STATUS_BITS-1:0] status;
      logic [skt_pkg::POS_BITS-1:0]    position;
      logic [skt_pkg::POS_BITS-1:0]    total;
   } table_reply_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   logic [skt_pkg::CMD_BITS-1:0]     req_command = '0;
   logic [skt_pkg::REQ_KEY_BITS-1:0] req_key = '0;
   logic [skt_pkg::WEIGHT_BITS-1:0]  req_weight = '0;
   logic [skt_pkg::COLOR_BITS-1:0]   req_color_code = '0;
   logic                             req_peel_edible = 1'b0;
   logic                             req_spiky = 1'b0;
   logic                             rsp_strobe;
   logic [skt_pkg::STATUS_BITS-1:0]  rsp_status;
   logic [skt_pkg::POS_BITS-1:0]     rsp_position;
   logic [skt_pkg::POS_BITS-1:0]     rsp_entry_total;

   // shadow copy of the table and its fill count
   table_entry_type model_table [TABLE_DEPTH];
   int              held_count = 0;

   table_cmd_type   pending_cmds [$];
   table_reply_type expected_replies [$];
   logic [skt_pkg::REQ_KEY_BITS-1:0] key_pool [KEY_POOL_SIZE];

   table_cmd_type   current_cmd;
   bit              holding = 1'b0;
   bit              req_accepted = 1'b0;
   int              issued_count = 0;
   int              queued_total = 0;
   int              accepted_total = 0;
   int              error_count = 0;

   sorted_keyed_table #(
      .DEPTH    (TABLE_DEPTH),
      .KEY_BITS (skt_pkg::REQ_KEY_BITS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_key         (req_key),
      .req_weight      (req_weight),
      .req_color_code  (req_color_code),
      .req_peel_edible (req_peel_edible),
      .req_spiky       (req_spiky),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_entry_total (rsp_entry_total)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply one command to the shadow table and return the reply it must give.
   // Delete and set-flag act on the lowest matching index; insert lands in
   // front of any held entry of equal weight.
   function automatic table_reply_type apply_table_command(table_cmd_type c);
      table_reply_type r;
      int              i;
      int              hit_idx;
      r.status   = skt_pkg::STATUS_DONE;
      r.position = '0;
      hit_idx    = -1;
      for (i = 0; i < held_count; i++) begin
         if (hit_idx < 0 && model_table[i].key == c.key) hit_idx = i;
      end
      case (c.command)
         skt_pkg::CMD_INSERT: begin
            if (held_count >= TABLE_DEPTH) begin
               r.status = skt_pkg::STATUS_FULL;
            end else begin
               i = held_count;
               while (i > 0 && !(c.weight > model_table[i-1].weight)) begin
                  model_table[i] = model_table[i-1];
                  i--;
               end
               model_table[i] = '{c.key, c.weight, c.color, c.peel, c.spiky};
               held_count++;
               r.position = skt_pkg::POS_BITS'(i);
            end
         end
         skt_pkg::CMD_DELETE: begin
            if (hit_idx < 0) begin
               r.status = skt_pkg::STATUS_NOT_FOUND;
            end else begin
               for (i = hit_idx; i + 1 < held_count; i++) model_table[i] = model_table[i+1];
               held_count--;
               r.position = skt_pkg::POS_BITS'(hit_idx);
            end
         end
         skt_pkg::CMD_FLAG: begin
            if (hit_idx < 0) begin
               r.status = skt_pkg::STATUS_NOT_FOUND;
            end else begin
               model_table[hit_idx].spiky = 1'b1;
               r.position = skt_pkg::POS_BITS'(hit_idx);
            end
         end
         default: ;  // unused code: table untouched, plain done reply
      endcase
      r.total = skt_pkg::POS_BITS'(held_count);
      return r;
   endfunction

   task automatic compare_field(string field_name, logic [skt_pkg::POS_BITS-1:0] expv,
                                logic [skt_pkg::POS_BITS-1:0] actv);
      if (actv !== expv) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, field_name, expv, actv);
         error_count++;
      end
   endtask

   task automatic queue_cmd(logic [skt_pkg::CMD_BITS-1:0] command,
                            logic [skt_pkg::REQ_KEY_BITS-1:0] key,
                            logic [skt_pkg::WEIGHT_BITS-1:0] weight,
                            logic [skt_pkg::COLOR_BITS-1:0] color,
                            logic peel, logic spiky);
      table_cmd_type c;
      c = '{command, key, weight, color, peel, spiky};
      pending_cmds.push_back(c);
      queued_total++;
   endtask

   // Draw one random command. Keys come mostly from a small pool so that
   // deletes and flags hit, and duplicates pile up; weights often snap to a
   // few levels (extremes included) so equal weights are common.
   task automatic queue_random_cmd(int insert_pct);
      table_cmd_type c;
      int            roll;
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) c.command = skt_pkg::CMD_INSERT;
      else if (roll >= 97) c.command = CMD_UNUSED;
      else if ($urandom_range(0, 1) == 0) c.command = skt_pkg::CMD_DELETE;
      else c.command = skt_pkg::CMD_FLAG;
      if ($urandom_range(0, 99) < 85) c.key = key_pool[$urandom_range(0, KEY_POOL_SIZE-1)];
      else c.key = $urandom;
      if ($urandom_range(0, 99) < 40)
         c.weight = skt_pkg::WEIGHT_BITS'($urandom_range(0, 3)) * 16'd21845;
      else
         c.weight = skt_pkg::WEIGHT_BITS'($urandom);
      c.color = skt_pkg::COLOR_BITS'($urandom);
      c.peel  = 1'($urandom);
      c.spiky = 1'($urandom);
      pending_cmds.push_back(c);
      queued_total++;
   endtask

   // Stimulus, reset and end of run.
   initial begin
      int n;
      int phase_len;
      int insert_pct;

      key_pool[0] = '0;
      key_pool[1] = '1;
      for (n = 2; n < KEY_POOL_SIZE; n++) key_pool[n] = $urandom;

      // directed: empty-table misses and the unused code
      queue_cmd(skt_pkg::CMD_DELETE, 32'h0, 16'h0, 8'h0, 1'b0, 1'b0);
      queue_cmd(skt_pkg::CMD_FLAG, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
      queue_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
      // field extremes, then an equal weight and a duplicate key
      queue_cmd(skt_pkg::CMD_INSERT, 32'h0, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
      queue_cmd(skt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 16'h0, 8'h0, 1'b0, 1'b0);
      queue_cmd(skt_pkg::CMD_INSERT, 32'h0, 16'hFFFF, 8'h5A, 1'b0, 1'b0);
      queue_cmd(skt_pkg::CMD_FLAG, 32'h0, 16'h0, 8'h0, 1'b0, 1'b0);
      queue_cmd(skt_pkg::CMD_DELETE, 32'h0, 16'h0, 8'h0, 1'b0, 1'b0);
      queue_cmd(skt_pkg::CMD_DELETE, 32'hFFFF_FFFF, 16'h0, 8'h0, 1'b0, 1'b0);
      queue_cmd(skt_pkg::CMD_FLAG, 32'h0, 16'h0, 8'h0, 1'b0, 1'b0);
      // fill to the top, several at one weight, then refuse one more
      for (n = 0; n < TABLE_DEPTH - 1; n++)
         queue_cmd(skt_pkg::CMD_INSERT, 32'h1000 + n,
                   (n % 3 == 0) ? 16'd100 : 16'(n * 4000),
                   8'(n * 17), 1'(n), 1'(n >> 1));
      queue_cmd(skt_pkg::CMD_INSERT, 32'hA5A5_A5A5, 16'd100, 8'hC3, 1'b1, 1'b0);
      queue_cmd(skt_pkg::CMD_DELETE, 32'h1006, 16'h0, 8'h0, 1'b0, 1'b0);
      queue_cmd(skt_pkg::CMD_DELETE, 32'h0, 16'h0, 8'h0, 1'b0, 1'b0);

      // random: phases that lean toward filling, churning or draining
      n = 0;
      while (n < RANDOM_CMDS) begin
         phase_len = $urandom_range(20, 60);
         case ($urandom_range(0, 2))
            0:       insert_pct = 85;
            1:       insert_pct = 50;
            default: insert_pct = 15;
         endcase
         repeat (phase_len) begin
            queue_random_cmd(insert_pct);
            n++;
         end
      end

      // hold reset, then release it at a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // hold until every beat is taken and every reply is in, then drain
      wait (accepted_total == queued_total);
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_replies.size() != 0) error_count++;

      if (error_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb failed");
      $finish;
   end

   // Sender: present the next beat at the falling edge and hold it until the
   // block takes it. Drop start at random, even while busy, so that gaps land
   // on every phase of the table walk; never idle inside the calm window.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         holding = 1'b0;
      end else begin
         if (req_accepted) holding = 1'b0;
         if (!holding && pending_cmds.size() != 0) begin
            current_cmd = pending_cmds.pop_front();
            holding = 1'b1;
            issued_count++;
            req_command     <= current_cmd.command;
            req_key         <= current_cmd.key;
            req_weight      <= current_cmd.weight;
            req_color_code  <= current_cmd.color;
            req_peel_edible <= current_cmd.peel;
            req_spiky       <= current_cmd.spiky;
         end
         if (holding)
            start <= (issued_count >= CALM_FIRST && issued_count < CALM_LAST) ||
                     ($urandom_range(0, 99) >= IDLE_PCT);
         else
            start <= 1'b0;
      end
   end

   // Monitor: at each rising edge check a reply beat against the oldest
   // expectation, then predict the reply of any request beat taken here.
   always @(posedge clock) begin
      table_reply_type exp_reply;
      table_cmd_type   taken;
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: reply with none expected, expected none, actual %0d/%0d/%0d",
                        $time, rsp_status, rsp_position, rsp_entry_total);
               error_count++;
            end else begin
               exp_reply = expected_replies.pop_front();
               compare_field("status", skt_pkg::POS_BITS'(exp_reply.status),
                             skt_pkg::POS_BITS'(rsp_status));
               compare_field("position", exp_reply.position, rsp_position);
               compare_field("entry_total", exp_reply.total, rsp_entry_total);
            end
         end
         if (start && busy === 1'b0) begin
            taken = '{req_command, req_key, req_weight, req_color_code,
                      req_peel_edible, req_spiky};
            expected_replies.push_back(apply_table_command(taken));
            accepted_total++;
         end
         req_accepted <= start && busy === 1'b0;
      end
   end

endmodule
